### rtl/rmf_pkg.sv
package rmf_pkg;

    localparam int WSIZE_W  = 4;
    localparam int RWIDTH_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd1;

    localparam logic [WSIZE_W-1:0]  WINDOW_SIZE_RST = 4'd3;
    localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RST   = 13'd640;

    typedef struct packed {
        logic               shift;
        logic               rank_en;
        logic               med_en;
        logic [WSIZE_W-1:0] win_size;
    } rmf_win_ctrl_t;

endpackage

### rtl/rmf_cell.sv
module rmf_cell
    import rmf_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int NCELLS     = 15,
    parameter int IDX        = 0,
    parameter int RK_W       = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rmf_win_ctrl_t                ctrl,
    input  logic [PIXEL_BITS-1:0]        pix_prev,
    input  logic [NCELLS*PIXEL_BITS-1:0] pix_all,
    input  logic [NCELLS-1:0]            active,
    output logic [PIXEL_BITS-1:0]        pix,
    output logic [RK_W-1:0]              rank
);

    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] pix_next;
    logic [RK_W-1:0]       rank_reg;
    logic [RK_W-1:0]       rank_next;
    logic [NCELLS-1:0]     below;

    // entries ranked below this one: smaller, or equal and newer
    always_comb
    begin
        for (int j = 0; j < NCELLS; j++)
        begin
            below[j] = active[j] &&
                ((pix_all[j*PIXEL_BITS +: PIXEL_BITS] < pix_reg) ||
                 ((j < IDX) && (pix_all[j*PIXEL_BITS +: PIXEL_BITS] == pix_reg)));
        end
    end

    assign pix_next  = ctrl.shift ? pix_prev : pix_reg;
    assign rank_next = ctrl.rank_en ? RK_W'($countones(below)) : rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else
        begin
            pix_reg <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
    end

    assign pix  = pix_reg;
    assign rank = rank_reg;

endmodule

### rtl/rmf_window.sv
module rmf_window
    import rmf_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int NCELLS     = 15,
    parameter int IDX_W      = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmf_win_ctrl_t         ctrl,
    input  logic [PIXEL_BITS-1:0] pixel_in,
    input  logic [IDX_W-1:0]      flush_addr,
    output logic [PIXEL_BITS-1:0] median,
    output logic [PIXEL_BITS-1:0] flush_pix
);

    localparam int RK_W = $clog2(NCELLS);

    logic [PIXEL_BITS-1:0]        pix [NCELLS];
    logic [RK_W-1:0]              rank [NCELLS];
    logic [NCELLS*PIXEL_BITS-1:0] pix_flat;
    logic [NCELLS-1:0]            active;
    logic [RK_W-1:0]              half_rk;
    logic [PIXEL_BITS-1:0]        med_reg;
    logic [PIXEL_BITS-1:0]        med_next;
    logic [PIXEL_BITS-1:0]        med_sel;

    assign half_rk = RK_W'({1'b0, ctrl.win_size[WSIZE_W-1:1]});

    genvar gi;
    generate
        for (gi = 0; gi < NCELLS; gi++)
        begin : g_cell
            logic [PIXEL_BITS-1:0] prev;

            if (gi == 0)
            begin : g_head
                assign prev = pixel_in;
            end
            else
            begin : g_body
                assign prev = pix[gi-1];
            end

            assign pix_flat[gi*PIXEL_BITS +: PIXEL_BITS] = pix[gi];
            assign active[gi] = (32'(gi) < 32'(ctrl.win_size));

            rmf_cell #(
                .PIXEL_BITS (PIXEL_BITS),
                .NCELLS     (NCELLS),
                .IDX        (gi),
                .RK_W       (RK_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .pix_prev (prev),
                .pix_all  (pix_flat),
                .active   (active),
                .pix      (pix[gi]),
                .rank     (rank[gi])
            );
        end
    endgenerate

    // the cell whose rank is half the window holds the median
    always_comb
    begin
        med_sel   = '0;
        flush_pix = '0;
        for (int i = 0; i < NCELLS; i++)
        begin
            if (active[i] && (rank[i] == half_rk))
            begin
                med_sel = med_sel | pix[i];
            end
            if (flush_addr == IDX_W'(i))
            begin
                flush_pix = pix[i];
            end
        end
    end

    assign med_next = ctrl.med_en ? med_sel : med_reg;

    always_ff @(posedge clk)
    begin
        med_reg <= med_next;
    end

    assign median = med_reg;

endmodule

### rtl/row_median_filter.sv
// row_median_filter: horizontal sliding median over raster-order pixels.
// Input channel in_valid/in_ready carries pixel_in; output channel
// out_valid/out_ready carries pixel_out, column, burst_last, setting_error.
// Config channel cfg_valid/cfg_ready (always ready) writes register
// cfg_index with cfg_data: 0 window_size, 1 row_width; writing either
// restarts the row at column 0. Write config only while the block is idle.
// Each accepted item shifts into a chain of MAX_WINDOW cells; the next cycle
// every cell ranks itself against the window, the cycle after the median is
// selected, then results go out one per cycle, unless the output stalls,
// through a single output register. Unless its settings are in error, the
// last item of a row also emits window_size/2 results for the edge flush.
// in_ready is low while an item's results are being produced; an output
// stall holds the output register and the sequencer waits on it.
// Reset clears the window to zeros, column to 0, window_size to 3 and
// row_width to 640; no clearing pass is needed.
module row_median_filter
    import rmf_pkg::*;
#(
    parameter int MAX_WINDOW = 15,
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PIXEL_BITS-1:0]         pixel_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PIXEL_BITS-1:0]         pixel_out,
    output logic [$clog2(MAX_WIDTH)-1:0]  column,
    output logic                          burst_last,
    output logic                          setting_error,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [RWIDTH_W-1:0]           cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = COL_W + 1;
    localparam int CMP_W  = (WID_W > RWIDTH_W) ? WID_W : RWIDTH_W;
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int HALF_W = WSIZE_W - 1;

    typedef enum logic [1:0] {ST_IDLE, ST_RANK, ST_MED, ST_EMIT} state_t;

    state_t                state_reg, state_next;
    logic [WSIZE_W-1:0]    wsize_reg, wsize_next;
    logic [RWIDTH_W-1:0]   rwidth_reg, rwidth_next;
    logic [COL_W-1:0]      colcnt_reg, colcnt_next;
    logic [PIXEL_BITS-1:0] p_reg, p_next;
    logic [COL_W-1:0]      c_reg, c_next;
    logic                  last_reg, last_next;
    logic                  err_reg, err_next;
    logic [HALF_W-1:0]     half_reg, half_next;
    logic                  prim_reg, prim_next;
    logic                  prim_med_reg, prim_med_next;
    logic [HALF_W-1:0]     fidx_reg, fidx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0] pixel_out_reg, pixel_out_next;
    logic [COL_W-1:0]      column_reg, column_next;
    logic                  burst_last_reg, burst_last_next;
    logic                  setting_error_reg, setting_error_next;

    logic [WID_W-1:0]      width;
    logic [COL_W-1:0]      c_in;
    logic                  last_in;
    logic                  err_in;
    logic [COL_W-1:0]      half_col;
    logic                  c_low;
    logic                  c_mid;
    logic [HALF_W-1:0]     flush_n;
    logic [HALF_W-1:0]     flush_rel;
    logic                  load_ok;
    logic                  in_accept;
    rmf_win_ctrl_t         win_ctrl;
    logic [PIXEL_BITS-1:0] median;
    logic [PIXEL_BITS-1:0] flush_pix;

    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    // effective row width, column, row-end flag and setting error of the incoming item
    always_comb
    begin
        if (CMP_W'(rwidth_reg) > CMP_W'(MAX_WIDTH))
        begin
            width = WID_W'(MAX_WIDTH);
        end
        else
        begin
            width = WID_W'(rwidth_reg);
        end
        c_in    = ({1'b0, colcnt_reg} >= width) ? '0 : colcnt_reg;
        last_in = (width == '0) || (({1'b0, c_in} + WID_W'(1)) >= width);
        err_in  = !wsize_reg[0] || (WID_W'(wsize_reg) >= width) ||
                  (32'(wsize_reg) > 32'(MAX_WINDOW));
    end

    assign half_col  = COL_W'(half_reg);
    assign c_low     = (c_reg < half_col);
    assign c_mid     = (c_reg >= COL_W'({half_reg, 1'b0}));
    assign flush_n   = (last_reg && !err_reg) ? half_reg : '0;
    assign flush_rel = half_reg - HALF_W'(1) - fidx_reg;
    assign load_ok   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next         = state_reg;
        wsize_next         = wsize_reg;
        rwidth_next        = rwidth_reg;
        colcnt_next        = colcnt_reg;
        p_next             = p_reg;
        c_next             = c_reg;
        last_next          = last_reg;
        err_next           = err_reg;
        half_next          = half_reg;
        prim_next          = prim_reg;
        prim_med_next      = prim_med_reg;
        fidx_next          = fidx_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        pixel_out_next     = pixel_out_reg;
        column_next        = column_reg;
        burst_last_next    = burst_last_reg;
        setting_error_next = setting_error_reg;
        win_ctrl.win_size  = wsize_reg;
        win_ctrl.shift     = 1'b0;
        win_ctrl.rank_en   = 1'b0;
        win_ctrl.med_en    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    win_ctrl.shift = 1'b1;
                    p_next         = pixel_in;
                    c_next         = c_in;
                    last_next      = last_in;
                    err_next       = err_in;
                    half_next      = wsize_reg[WSIZE_W-1:1];
                    colcnt_next    = last_in ? '0 : c_in + COL_W'(1);
                    state_next     = ST_RANK;
                end
            end
            ST_RANK:
            begin
                win_ctrl.rank_en = 1'b1;
                state_next       = ST_MED;
            end
            ST_MED:
            begin
                win_ctrl.med_en = 1'b1;
                prim_next       = err_reg || c_low || c_mid;
                prim_med_next   = !err_reg && !c_low && c_mid;
                fidx_next       = '0;
                if (!(err_reg || c_low || c_mid) && (flush_n == '0))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next     = 1'b1;
                    setting_error_next = err_reg;
                    if (prim_reg)
                    begin
                        prim_next       = 1'b0;
                        pixel_out_next  = prim_med_reg ? median : p_reg;
                        column_next     = prim_med_reg ? c_reg - half_col : c_reg;
                        burst_last_next = (flush_n == '0);
                        if (flush_n == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        pixel_out_next  = flush_pix;
                        column_next     = c_reg - half_col + COL_W'(1) + COL_W'(fidx_reg);
                        burst_last_next = ((fidx_reg + HALF_W'(1)) == flush_n);
                        fidx_next       = fidx_reg + HALF_W'(1);
                        if ((fidx_reg + HALF_W'(1)) == flush_n)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE:
                begin
                    wsize_next  = cfg_data[WSIZE_W-1:0];
                    colcnt_next = '0;
                end
                CFG_ROW_WIDTH:
                begin
                    rwidth_next = cfg_data;
                    colcnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            wsize_reg         <= WINDOW_SIZE_RST;
            rwidth_reg        <= ROW_WIDTH_RST;
            colcnt_reg        <= '0;
            p_reg             <= '0;
            c_reg             <= '0;
            last_reg          <= 1'b0;
            err_reg           <= 1'b0;
            half_reg          <= '0;
            prim_reg          <= 1'b0;
            prim_med_reg      <= 1'b0;
            fidx_reg          <= '0;
            out_valid_reg     <= 1'b0;
            pixel_out_reg     <= '0;
            column_reg        <= '0;
            burst_last_reg    <= 1'b0;
            setting_error_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            wsize_reg         <= wsize_next;
            rwidth_reg        <= rwidth_next;
            colcnt_reg        <= colcnt_next;
            p_reg             <= p_next;
            c_reg             <= c_next;
            last_reg          <= last_next;
            err_reg           <= err_next;
            half_reg          <= half_next;
            prim_reg          <= prim_next;
            prim_med_reg      <= prim_med_next;
            fidx_reg          <= fidx_next;
            out_valid_reg     <= out_valid_next;
            pixel_out_reg     <= pixel_out_next;
            column_reg        <= column_next;
            burst_last_reg    <= burst_last_next;
            setting_error_reg <= setting_error_next;
        end
    end

    rmf_window #(
        .PIXEL_BITS (PIXEL_BITS),
        .NCELLS     (MAX_WINDOW),
        .IDX_W      (IDX_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .pixel_in   (pixel_in),
        .flush_addr (IDX_W'(flush_rel)),
        .median     (median),
        .flush_pix  (flush_pix)
    );

    assign out_valid     = out_valid_reg;
    assign pixel_out     = pixel_out_reg;
    assign column        = column_reg;
    assign burst_last    = burst_last_reg;
    assign setting_error = setting_error_reg;

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside the emit state");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && setting_error |-> burst_last)
        else $error("error result not marked last");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("item accepted while previous item in progress");

    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        (colcnt_reg == '0) || ({1'b0, colcnt_reg} < width))
        else $error("column counter beyond row width");

    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && !prim_reg |-> (fidx_reg < flush_n))
        else $error("edge flush index out of range");

endmodule

### dv/tb_row_median_filter.sv
`timescale 1ns / 1ps

module tb_row_median_filter
    import rmf_pkg::*;
();

    localparam int MAX_WINDOW     = 15;
    localparam int MAX_WIDTH      = 4096;
    localparam int PIXEL_BITS     = 8;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_GAP        = 12;
    localparam int RANDOM_ITEMS   = 50;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef struct packed {
        pixel_t           pix;
        logic [COL_W-1:0] col;
        logic             last;
        logic             err;
    } filt_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pixel_t               pixel_in;
    logic                 out_valid;
    logic                 out_ready;
    pixel_t               pixel_out;
    logic [COL_W-1:0]     column;
    logic                 burst_last;
    logic                 setting_error;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RWIDTH_W-1:0]  cfg_data;

    row_median_filter #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_out     (pixel_out),
        .column        (column),
        .burst_last    (burst_last),
        .setting_error (setting_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pixel_t              win_hist [MAX_WINDOW];
    logic [COL_W-1:0]    col_next;
    logic [WSIZE_W-1:0]  win_len;
    logic [RWIDTH_W-1:0] row_len;
    filt_result_t        expected_q [$];
    int unsigned         fail_count;
    bit                  idle_en;
    int unsigned         rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void filter_reset();
        for (int i = 0; i < MAX_WINDOW; i++)
            win_hist[i] = '0;
        col_next = '0;
        win_len  = WINDOW_SIZE_RST;
        row_len  = ROW_WIDTH_RST;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [RWIDTH_W-1:0] data);
        if (idx == CFG_WINDOW_SIZE)
        begin
            win_len  = data[WSIZE_W-1:0];
            col_next = '0;
        end
        else if (idx == CFG_ROW_WIDTH)
        begin
            row_len  = data;
            col_next = '0;
        end
    endfunction

    function automatic pixel_t window_median(int unsigned w);
        pixel_t sorted [MAX_WINDOW];
        pixel_t t;
        for (int i = 0; i < MAX_WINDOW; i++)
            sorted[i] = win_hist[i];
        for (int i = 1; i < w; i++)
            for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--)
            begin
                t           = sorted[j];
                sorted[j]   = sorted[j-1];
                sorted[j-1] = t;
            end
        return sorted[w / 2];
    endfunction

    function automatic void predict_pixel(pixel_t p);
        int unsigned  w;
        int unsigned  width;
        int unsigned  c;
        int unsigned  half;
        bit           row_end;
        bit           bad;
        filt_result_t burst [$];
        w     = win_len;
        width = (row_len > MAX_WIDTH) ? MAX_WIDTH : row_len;
        c     = col_next;
        if (c >= width)
            c = 0;
        row_end = (width == 0) || (c + 1 >= width);
        for (int i = MAX_WINDOW - 1; i > 0; i--)
            win_hist[i] = win_hist[i-1];
        win_hist[0] = p;
        col_next = row_end ? '0 : COL_W'(c + 1);
        bad = (w % 2 == 0) || (w >= width) || (w > MAX_WINDOW);
        if (bad)
        begin
            expected_q.push_back(filt_result_t'{p, COL_W'(c), 1'b1, 1'b1});
            return;
        end
        half = w / 2;
        if (c < half)
            burst.push_back(filt_result_t'{p, COL_W'(c), 1'b0, 1'b0});
        else if (c >= 2 * half)
            burst.push_back(filt_result_t'{window_median(w), COL_W'(c - half), 1'b0, 1'b0});
        // right edge flush
        if (row_end)
            for (int i = 0; i < half; i++)
                burst.push_back(filt_result_t'{win_hist[half-1-i], COL_W'(c - half + 1 + i),
                                               1'b0, 1'b0});
        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[i])
            expected_q.push_back(burst[i]);
    endfunction

    task automatic send_pixel(pixel_t p);
        int unsigned gap;
        gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pixel(p);
    endtask

    task automatic send_random(int unsigned n);
        repeat (n)
            send_pixel(pixel_t'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // silent items may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RWIDTH_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic set_filter(int unsigned w, int unsigned width);
        logic [RWIDTH_W-1:0] data;
        drain();
        // upper bits of the window write are don't-care
        data = RWIDTH_W'($urandom);
        data[WSIZE_W-1:0] = WSIZE_W'(w);
        write_reg(CFG_WINDOW_SIZE, data);
        write_reg(CFG_ROW_WIDTH, RWIDTH_W'(width));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd17);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd127);
        send_pixel(8'd1);
    endtask

    task automatic test_edge_cases();
        set_filter(3, 5);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd1);
        send_pixel(8'd254);

        // window of one passes every pixel through the median path
        set_filter(1, 3);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);

        // write to an unused index must not restart the row
        set_filter(3, 5);
        send_pixel(8'd10);
        send_pixel(8'd200);
        drain();
        write_reg(CFG_UNUSED, RWIDTH_W'($urandom));
        cfg_valid <= 1'b0;
        send_pixel(8'd30);
        send_pixel(8'd90);
        send_pixel(8'd60);

        // even window
        set_filter(4, 6);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // window not below row width
        set_filter(5, 5);
        send_pixel(8'd7);

        // zero row width
        set_filter(3, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
    endtask

    task automatic test_random_rows();
        int unsigned sent;
        int unsigned w;
        int unsigned width;
        int unsigned n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    w     = 2 * $urandom_range(0, 7);
                    width = $urandom_range(1, 20);
                end
                1:
                begin
                    w     = 2 * $urandom_range(0, 7) + 1;
                    width = $urandom_range(0, w);
                end
                default:
                begin
                    w     = 2 * $urandom_range(0, 7) + 1;
                    width = w + $urandom_range(1, 8);
                end
            endcase
            idle_en = ($urandom_range(0, 3) != 0);
            set_filter(w, width);
            n = (width == 0) ? 3 : width * $urandom_range(1, 2) + $urandom_range(0, width - 1);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            send_random(n);
            sent += n;
        end
        idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_filter(7, 10);
        idle_en = 1'b0;
        rx_hold = HOLD_CYCLES;
        send_random(20);
        idle_en = 1'b1;
    endtask

    task automatic test_max_row();
        // oversized width acts as the largest row
        set_filter(MAX_WINDOW, 8191);
        idle_en = 1'b0;
        send_random(12);
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        pixel_in   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_en    = 1'b1;
        rx_hold    = 0;
        fail_count = 0;
        filter_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_edge_cases();
        test_random_rows();
        test_output_backpressure();
        test_max_row();

        drain();
        if (fail_count == 0)
            $display("PASS row_median_filter");
        else
            $display("FAIL row_median_filter");
        $finish;
    end

    initial
    begin
        int unsigned rx_gap;
        rx_gap    = 0;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready && idle_en)
                rx_gap = $urandom_range(0, MAX_GAP);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                rx_gap--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        filt_result_t exp_r;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected item: pixel_out %0d column %0d", pixel_out, column);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (pixel_out !== exp_r.pix)
                    begin
                        $error("pixel_out expected %0d actual %0d", exp_r.pix, pixel_out);
                        fail_count++;
                    end
                    if (column !== exp_r.col)
                    begin
                        $error("column expected %0d actual %0d", exp_r.col, column);
                        fail_count++;
                    end
                    if (burst_last !== exp_r.last)
                    begin
                        $error("burst_last expected %0b actual %0b", exp_r.last, burst_last);
                        fail_count++;
                    end
                    if (setting_error !== exp_r.err)
                    begin
                        $error("setting_error expected %0b actual %0b", exp_r.err,
                               setting_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("FAIL row_median_filter");
                $finish;
            end
        end
    end

endmodule
